// File: design/sfr_pkg.sv
// shared types and constants of the sequenced fragment receiver
package sfr_pkg;

  // consumer-side limit on the bytes of one fragment set
  localparam int unsigned BufferBytes = 32768;

  // configuration register indexes and port widths
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgFragmentSize   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxMessageBytes = 2'd1;

  // register reset values
  localparam logic [14:0] FragmentSizeRst    = 15'd1300;
  localparam logic [15:0] MaxMessageBytesRst = 16'd32768;

  // result status codes
  typedef enum logic [2:0] {
    StWhole       = 3'd0,
    StReassembled = 3'd1,
    StHeld        = 3'd2,
    StStale       = 3'd3,
    StMissed      = 3'd4,
    StBadLen      = 3'd5,
    StTooLong     = 3'd6
  } status_e;

  // one received datagram header
  typedef struct packed {
    logic [31:0] header_word;
    logic [15:0] frag_start;
    logic [15:0] frag_len;
    logic [15:0] payload_bytes;
  } hdr_t;

  // one result
  typedef struct packed {
    status_e     status;
    logic [15:0] message_length;
    logic [30:0] skipped_count;
    logic [30:0] seq_out;
  } res_t;

  // configuration register contents
  typedef struct packed {
    logic [14:0] full_frag_bytes;
    logic [15:0] max_message_bytes;
  } cfg_t;

endpackage

// File: design/sfr_if.sv
// request and result channel interfaces of the sequenced fragment receiver
interface sfr_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] header_word;
  logic signed [15:0] frag_start;
  logic signed [15:0] frag_len;
  logic        [15:0] payload_bytes;

  modport source (output valid, header_word, frag_start, frag_len, payload_bytes,
                  input ready);
  modport sink (input valid, header_word, frag_start, frag_len, payload_bytes,
                output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] message_length;
  logic [30:0] skipped_count;
  logic [30:0] seq_out;

  modport source (output valid, status, message_length, skipped_count, seq_out,
                  input ready);
  modport sink (input valid, status, message_length, skipped_count, seq_out,
                output ready);
endinterface

// File: design/sfr_cfg_regs.sv
// configuration registers of the sequenced fragment receiver
module sfr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::CfgDataW-1:0] cfg_data_i,
  output sfr_pkg::cfg_t                cfg_o
);

  logic [14:0] frag_size_q, frag_size_d;
  logic [15:0] max_msg_q, max_msg_d;

  // register write decode, unknown indexes are dropped
  always_comb begin
    frag_size_d = frag_size_q;
    max_msg_d   = max_msg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sfr_pkg::CfgFragmentSize:    frag_size_d = cfg_data_i[14:0];
        sfr_pkg::CfgMaxMessageBytes: max_msg_d   = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frag_size_q <= sfr_pkg::FragmentSizeRst;
      max_msg_q   <= sfr_pkg::MaxMessageBytesRst;
    end else begin
      frag_size_q <= frag_size_d;
      max_msg_q   <= max_msg_d;
    end
  end

  assign cfg_o.full_frag_bytes   = frag_size_q;
  assign cfg_o.max_message_bytes = max_msg_q;

endmodule

// File: design/sfr_seq_check.sv
// sequence and fragment checks with the channel state registers
module sfr_seq_check (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  sfr_pkg::hdr_t hdr_i,
  input  sfr_pkg::cfg_t cfg_i,
  output sfr_pkg::res_t res_o
);

  logic [30:0] last_seq_q, last_seq_d;
  logic [30:0] asm_seq_q, asm_seq_d;
  logic [15:0] asm_bytes_q, asm_bytes_d;

  logic [30:0] seq;
  logic        frag;
  logic        stale;
  logic [15:0] asm_eff;
  logic [16:0] sum;
  logic [15:0] new_total;

  assign seq       = hdr_i.header_word[30:0];
  assign frag      = hdr_i.header_word[31];
  assign stale     = (seq <= last_seq_q);
  // a new fragment sequence starts from an empty buffer
  assign asm_eff   = (seq != asm_seq_q) ? 16'd0 : asm_bytes_q;
  assign sum       = {1'b0, asm_eff} + {1'b0, hdr_i.frag_len};
  assign new_total = sum[15:0];

  // classify the header and work out the next channel state
  always_comb begin
    res_o.status         = sfr_pkg::StStale;
    res_o.message_length = 16'd0;
    res_o.skipped_count  = 31'd0;
    res_o.seq_out        = seq;
    last_seq_d           = last_seq_q;
    asm_seq_d            = asm_seq_q;
    asm_bytes_d          = asm_bytes_q;
    if (!stale) begin
      res_o.skipped_count = seq - last_seq_q - 31'd1;
      if (!frag) begin
        res_o.status         = sfr_pkg::StWhole;
        res_o.message_length = hdr_i.payload_bytes;
        last_seq_d           = seq;
      end else begin
        asm_seq_d   = seq;
        asm_bytes_d = asm_eff;
        if (hdr_i.frag_start[15] || (hdr_i.frag_start != asm_eff)) begin
          res_o.status = sfr_pkg::StMissed;
        end else if (hdr_i.frag_len[15] || (hdr_i.frag_len > hdr_i.payload_bytes) ||
                     (sum > 17'(sfr_pkg::BufferBytes))) begin
          res_o.status = sfr_pkg::StBadLen;
        end else if (hdr_i.frag_len == {1'b0, cfg_i.full_frag_bytes}) begin
          res_o.status = sfr_pkg::StHeld;
          asm_bytes_d  = new_total;
        end else if (new_total > cfg_i.max_message_bytes) begin
          res_o.status = sfr_pkg::StTooLong;
          asm_bytes_d  = new_total;
        end else begin
          res_o.status         = sfr_pkg::StReassembled;
          res_o.message_length = new_total;
          asm_bytes_d          = 16'd0;
          last_seq_d           = seq;
        end
      end
    end
  end

  // state advances only when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q  <= 31'd0;
      asm_seq_q   <= 31'd0;
      asm_bytes_q <= 16'd0;
    end else if (fire_i) begin
      last_seq_q  <= last_seq_d;
      asm_seq_q   <= asm_seq_d;
      asm_bytes_q <= asm_bytes_d;
    end
  end

endmodule

// File: design/sfr_out_stage.sv
// result register driving the result channel
module sfr_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  sfr_pkg::res_t res_i,
  output logic          free_o,
  sfr_out_if.source     out_o
);

  logic          valid_q, valid_d;
  sfr_pkg::res_t res_q;

  // register is free when empty or being drained this cycle
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.status         = res_q.status;
  assign out_o.message_length = res_q.message_length;
  assign out_o.skipped_count  = res_q.skipped_count;
  assign out_o.seq_out        = res_q.seq_out;

endmodule

// File: design/sequenced_fragment_receiver.sv
// top level of the sequenced fragment receiver
// Takes one datagram header per request and returns one result per request, in
// order. A request is taken into an input register, checked against the channel
// state (last accepted sequence, fragment set in progress, bytes assembled) in
// one pass of logic, and moves on into a result register once that register is
// free. The state is updated in the same cycle the result is registered, so
// one request per clock is sustained while the result side keeps up; a stalled
// result holds the input register and then backpressures the request side.
// Configuration writes are meant for idle periods only and take effect at once.
module sequenced_fragment_receiver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::CfgDataW-1:0] cfg_data_i,
  sfr_in_if.sink                       hdr_i,
  sfr_out_if.source                    res_o
);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::hdr_t hdr_q;
  sfr_pkg::res_t res;
  logic          in_valid_q, in_valid_d;
  logic          out_free;
  logic          fire;
  logic          in_take;

  sfr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register handshake
  assign fire        = in_valid_q && out_free;
  assign hdr_i.ready = !in_valid_q || fire;
  assign in_take     = hdr_i.valid && hdr_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hdr_q.header_word   <= hdr_i.header_word;
      hdr_q.frag_start    <= hdr_i.frag_start;
      hdr_q.frag_len      <= hdr_i.frag_len;
      hdr_q.payload_bytes <= hdr_i.payload_bytes;
    end
  end

  sfr_seq_check u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .hdr_i  (hdr_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  sfr_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (res_o)
  );

endmodule

// File: design/sfr_checker.sv
// port-level assertions for the sequenced fragment receiver
module sfr_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [15:0] message_length_i,
  input logic [30:0] skipped_count_i,
  input logic [30:0] seq_out_i
);

  logic out_fire;
  assign out_fire = out_valid_i && out_ready_i;

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(message_length_i) && $stable(skipped_count_i) && $stable(seq_out_i))
    else $error("result changed while stalled");

  // stale requests report no skip and no length
  a_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == sfr_pkg::StStale |->
      skipped_count_i == 31'd0 && message_length_i == 16'd0)
    else $error("stale result with nonzero fields");

  // only delivered messages carry a length
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != sfr_pkg::StWhole && status_i != sfr_pkg::StReassembled
      |-> message_length_i == 16'd0)
    else $error("length given on undelivered result");

  // a sequence repeated right after a whole datagram is stale
  a_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && status_i == sfr_pkg::StWhole) ##1
      (out_fire && seq_out_i == $past(seq_out_i)) |-> status_i == sfr_pkg::StStale)
    else $error("duplicate sequence not flagged stale");

endmodule

bind sequenced_fragment_receiver sfr_port_checks u_port_checks (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .status_i         (res_o.status),
  .message_length_i (res_o.message_length),
  .skipped_count_i  (res_o.skipped_count),
  .seq_out_i        (res_o.seq_out)
);
